// File: sv/derhdr_pkg.sv
// Shared types, constants and sizes for the DER tag/length header encoder.
package derhdr_pkg;

   localparam int TAG_BITS     = 32;
   localparam int LENGTH_BYTES = 8;

   localparam int LEN_W   = LENGTH_BYTES * 8;
   localparam int NGRP    = (TAG_BITS + 6) / 7;
   localparam int TAG_PAD = NGRP * 7;
   localparam int ID_MAX  = NGRP + 1;
   localparam int LEN_MAX = LENGTH_BYTES + 1;
   localparam int MAX_BYTES = ID_MAX + LEN_MAX;

   localparam int GRP_W  = $clog2(NGRP + 1);
   localparam int NB_W   = $clog2(LENGTH_BYTES + 1);
   localparam int CNT_W  = $clog2(MAX_BYTES + 1);
   localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int LIDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

   localparam logic [7:0] CLASS_LOW_MASK = 8'h1F;
   localparam logic [7:0] ID_LONG_FORM   = 8'h1F;
   localparam logic [7:0] CONT_BIT       = 8'h80;
   localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;
   localparam int         SHORT_TAG_MAX  = 30;
   localparam int         SHORT_LEN_MAX  = 127;

   typedef struct packed {
      logic [31:0] tag_number;
      logic [7:0]  class_bits;
      logic [63:0] content_length;
   } req_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       last;
      logic       bad_class;
   } rsp_type;

   // stage 1: captured request, class check done
   typedef struct packed {
      logic                bad;
      logic [7:0]          cls;
      logic [TAG_BITS-1:0] tag;
      logic [LEN_W-1:0]    len;
   } st1_type;

   // stage 2: per-group / per-byte nonzero flags and short-form flags
   typedef struct packed {
      logic                    bad;
      logic [7:0]              cls;
      logic [TAG_BITS-1:0]     tag;
      logic [LEN_W-1:0]        len;
      logic [NGRP-1:0]         grp_nz;
      logic [LENGTH_BYTES-1:0] lb_nz;
      logic                    short_tag;
      logic                    short_len;
   } st2_type;

   // stage 3: fully decoded header, ready for the byte emitter
   typedef struct packed {
      logic                bad;
      logic                short_tag;
      logic                short_len;
      logic [7:0]          cls;
      logic [TAG_BITS-1:0] tag;
      logic [LEN_W-1:0]    len;
      logic [GRP_W-1:0]    grp_cnt;
      logic [NB_W-1:0]     nb_cnt;
      logic [CNT_W-1:0]    id_cnt;
      logic [CNT_W-1:0]    total;
   } hdr_type;

endpackage

// File: sv/der_tag_length_header_encoder_unit.sv
// Top level of the DER identifier and length header encoder.
//
//  channel   ports                      handshake
//  --------  -------------------------  ------------------------------------
//  request   start, busy, req_data      taken on clock edge with start & !busy
//  result    rsp_valid, rsp_data        one octet per rsp_valid cycle, no stall
//
// The first header octet reaches the result ports once the request has passed
// stage 1, stage 2, stage 3 and the emitter header register.
// A request's header, sent from the emitter one octet at a time, has
// 1 octet for a bad class, else 2 to 15 (6 identifier + 9 length at most).
// The single-octet result port sets the sustained rate; the three decode
// stages keep accepting requests until they back up behind the emitter.
// busy rises only when stage 1 is full and cannot advance.
// Reset (synchronous) empties all stages; no request survives it.
module der_tag_length_header_encoder_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  derhdr_pkg::req_type req_data,
   output logic                rsp_valid,
   output derhdr_pkg::rsp_type rsp_data
);
   import derhdr_pkg::*;

   logic    front_free;
   logic    hdr_valid;
   logic    hdr_take;
   hdr_type hdr;

   // busy is a function of pipeline registers only
   assign busy = !front_free;

   // decode: class check, nonzero scan, header sizing
   derhdr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_req    (req_data),
      .in_free   (front_free),
      .out_take  (hdr_take),
      .out_valid (hdr_valid),
      .out_hdr   (hdr)
   );

   // serialize: identifier octets, then length octets, last flagged
   derhdr_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hdr_valid),
      .in_hdr    (hdr),
      .in_take   (hdr_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/derhdr_front.sv
// Three-stage decode pipeline: class check, nonzero scan, header sizing.
module derhdr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  derhdr_pkg::req_type in_req,
   output logic               in_free,
   input  logic               out_take,
   output logic               out_valid,
   output derhdr_pkg::hdr_type out_hdr
);
   import derhdr_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   logic    s2_valid_ff, s2_valid_in;
   logic    s3_valid_ff, s3_valid_in;
   st1_type s1_ff, s1_in;
   st2_type s2_ff, s2_in;
   hdr_type s3_ff, s3_in;

   logic s1_free, s2_free, s3_free;
   logic [TAG_PAD-1:0] tag_pad;
   logic [GRP_W-1:0]   grp_cnt;
   logic [NB_W-1:0]    nb_cnt;
   logic [CNT_W-1:0]   len_cnt;

   // a stage is free when empty or when its content moves on this cycle
   assign s3_free = !s3_valid_ff || out_take;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign in_free = s1_free;

   assign s1_valid_in = s1_free ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_free ? s2_valid_ff : s3_valid_ff;

   // stage 1
   always_comb begin
      s1_in.bad = |(in_req.class_bits & CLASS_LOW_MASK);
      s1_in.cls = in_req.class_bits;
      s1_in.tag = TAG_BITS'(in_req.tag_number);
      s1_in.len = LEN_W'(in_req.content_length);
   end

   // stage 2
   assign tag_pad = TAG_PAD'(s1_ff.tag);

   always_comb begin
      s2_in.bad = s1_ff.bad;
      s2_in.cls = s1_ff.cls;
      s2_in.tag = s1_ff.tag;
      s2_in.len = s1_ff.len;
      for (int j = 0; j < NGRP; j++) begin
         s2_in.grp_nz[j] = |tag_pad[7*j +: 7];
      end
      for (int j = 0; j < LENGTH_BYTES; j++) begin
         s2_in.lb_nz[j] = |s1_ff.len[8*j +: 8];
      end
      s2_in.short_tag = (s1_ff.tag <= TAG_BITS'(SHORT_TAG_MAX));
      s2_in.short_len = (s1_ff.len <= LEN_W'(SHORT_LEN_MAX));
   end

   // stage 3: highest nonzero group / byte gives the counts
   always_comb begin
      grp_cnt = '0;
      for (int j = 0; j < NGRP; j++) begin
         if (s2_ff.grp_nz[j]) begin
            grp_cnt = GRP_W'(j + 1);
         end
      end
      nb_cnt = '0;
      for (int j = 0; j < LENGTH_BYTES; j++) begin
         if (s2_ff.lb_nz[j]) begin
            nb_cnt = NB_W'(j + 1);
         end
      end
      s3_in.bad       = s2_ff.bad;
      s3_in.short_tag = s2_ff.short_tag;
      s3_in.short_len = s2_ff.short_len;
      s3_in.cls       = s2_ff.cls;
      s3_in.tag       = s2_ff.tag;
      s3_in.len       = s2_ff.len;
      s3_in.grp_cnt   = grp_cnt;
      s3_in.nb_cnt    = nb_cnt;
      s3_in.id_cnt    = s2_ff.short_tag ? CNT_W'(1) : CNT_W'(grp_cnt) + CNT_W'(1);
      len_cnt         = s2_ff.short_len ? CNT_W'(1) : CNT_W'(nb_cnt) + CNT_W'(1);
      s3_in.total     = s2_ff.bad ? CNT_W'(1) : s3_in.id_cnt + len_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ff <= s1_in;
      end
      if (s2_free) begin
         s2_ff <= s2_in;
      end
      if (s3_free) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_hdr   = s3_ff;

endmodule

// File: sv/derhdr_emit.sv
// Byte emitter: walks one decoded header out one octet per cycle.
module derhdr_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  derhdr_pkg::hdr_type in_hdr,
   output logic               in_take,
   output logic               rsp_valid,
   output derhdr_pkg::rsp_type rsp_data
);
   import derhdr_pkg::*;

   logic             e_valid_ff, e_valid_in;
   hdr_type          hdr_ff;
   logic [CNT_W-1:0] pos_ff, pos_in;

   logic [TAG_PAD-1:0] tag_pad;
   logic [6:0]         grp [NGRP];
   logic [7:0]         lb  [LENGTH_BYTES];
   logic [CNT_W-1:0]   gdiff, mpos, ldiff;
   logic [GIDX_W-1:0]  gidx;
   logic [LIDX_W-1:0]  lidx;
   logic               is_last;
   logic [7:0]         byte_val;

   assign tag_pad = TAG_PAD'(hdr_ff.tag);

   always_comb begin
      for (int j = 0; j < NGRP; j++) begin
         grp[j] = tag_pad[7*j +: 7];
      end
      for (int j = 0; j < LENGTH_BYTES; j++) begin
         lb[j] = hdr_ff.len[8*j +: 8];
      end
   end

   assign is_last = (pos_ff == hdr_ff.total - CNT_W'(1));
   assign in_take = !e_valid_ff || is_last;

   // groups go out most significant first; length bytes big-endian
   assign gdiff = CNT_W'(hdr_ff.grp_cnt) - pos_ff;
   assign gidx  = gdiff[GIDX_W-1:0];
   assign mpos  = pos_ff - hdr_ff.id_cnt;
   assign ldiff = CNT_W'(hdr_ff.nb_cnt) - mpos;
   assign lidx  = ldiff[LIDX_W-1:0];

   always_comb begin
      if (hdr_ff.bad) begin
         byte_val = 8'h00;
      end else if (pos_ff < hdr_ff.id_cnt) begin
         if (pos_ff == '0) begin
            byte_val = hdr_ff.short_tag ? (hdr_ff.tag[7:0] | hdr_ff.cls)
                                        : (hdr_ff.cls | ID_LONG_FORM);
         end else begin
            byte_val = {(pos_ff < CNT_W'(hdr_ff.grp_cnt)), grp[gidx]};
         end
      end else begin
         if (mpos == '0) begin
            byte_val = hdr_ff.short_len ? hdr_ff.len[7:0]
                                        : (LEN_LONG_FLAG | 8'(hdr_ff.nb_cnt));
         end else begin
            byte_val = lb[lidx];
         end
      end
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      pos_in     = pos_ff;
      if (in_take) begin
         e_valid_in = in_valid;
         pos_in     = '0;
      end else begin
         pos_in = pos_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         pos_ff     <= '0;
      end else begin
         e_valid_ff <= e_valid_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         hdr_ff <= in_hdr;
      end
   end

   assign rsp_valid            = e_valid_ff;
   assign rsp_data.header_byte = byte_val;
   assign rsp_data.last        = is_last;
   assign rsp_data.bad_class   = hdr_ff.bad;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the DER identifier/length header encoder: per-octet prediction.
module tb_top;
   import derhdr_pkg::*;

   // Octet predictor plus the queue of octets the block still owes us.
   class header_scoreboard;
      rsp_type pending_octets[$];
      int      mismatches;

      static function int bit_length(logic [63:0] v);
         int n;
         n = 0;
         while (v != 0) begin
            n++;
            v = v >> 1;
         end
         return n;
      endfunction

      function void append_octet(rsp_type o);
         pending_octets.insert(pending_octets.size(), o);
      endfunction

      function void push_octet(logic [7:0] b);
         rsp_type o;
         o.header_byte = b;
         o.last        = 1'b0;
         o.bad_class   = 1'b0;
         append_octet(o);
      endfunction

      function void note_error(string msg);
         if (mismatches < 10) $display("%0t: %s", $realtime, msg);
         mismatches++;
      endfunction

      // Expand one accepted request into the octets it must produce.
      function void note_request(req_type r);
         logic [63:0] tag;
         logic [63:0] len;
         logic [63:0] part;
         logic [7:0]  cls;
         rsp_type     o;
         int          groups;
         int          nbytes;
         cls = r.class_bits;
         if ((cls & CLASS_LOW_MASK) != 0) begin
            o.header_byte = 8'h00;
            o.last        = 1'b1;
            o.bad_class   = 1'b1;
            append_octet(o);
            return;
         end
         // fold tag and length to the configured widths
         tag = 64'({32'd0, r.tag_number} & ((65'd1 << TAG_BITS) - 65'd1));
         len = 64'(r.content_length & ((65'd1 << LEN_W) - 65'd1));

         if (tag <= SHORT_TAG_MAX) begin
            push_octet(tag[7:0] | cls);
         end else begin
            groups = (bit_length(tag) + 6) / 7;
            push_octet(cls | ID_LONG_FORM);
            for (int i = groups - 1; i > 0; i--) begin
               part = tag >> (7 * i);
               push_octet(CONT_BIT | {1'b0, part[6:0]});
            end
            push_octet({1'b0, tag[6:0]});
         end

         if (len <= SHORT_LEN_MAX) begin
            push_octet(len[7:0]);
         end else begin
            nbytes = (bit_length(len) + 7) / 8;
            push_octet(LEN_LONG_FLAG | nbytes[7:0]);
            for (int i = nbytes; i > 0; i--) begin
               part = len >> (8 * (i - 1));
               push_octet(part[7:0]);
            end
         end
         pending_octets[pending_octets.size() - 1].last = 1'b1;
      endfunction

      function void check_octet(rsp_type got);
         rsp_type want;
         if (pending_octets.size() == 0) begin
            note_error($sformatf("unexpected octet %02h last %0d bad_class %0d",
                                 got.header_byte, got.last, got.bad_class));
            return;
         end
         want = pending_octets.pop_front();
         if (got.header_byte !== want.header_byte || got.last !== want.last ||
             got.bad_class !== want.bad_class) begin
            note_error($sformatf({"octet error: expected %02h last %0d bad_class %0d,",
                                  " got %02h last %0d bad_class %0d"},
                                 want.header_byte, want.last, want.bad_class,
                                 got.header_byte, got.last, got.bad_class));
         end
      endfunction

      function int outstanding();
         return pending_octets.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   header_scoreboard octets = new;

   der_tag_length_header_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sample at the rising edge: the values seen here are the ones in force
   // before the edge, since the block updates its outputs by NBA. Results
   // are checked before the request is noted; the pipeline latency keeps a
   // request from producing an octet in the same cycle it is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) octets.check_octet(rsp_data);
         if (start && !busy) octets.note_request(req_data);
      end
   end

   // Present one request. Optional idle cycles first (start low), then start
   // goes high at a falling edge and stays there until an edge with busy low.
   // Every falling edge carries at most one update of start, so a request
   // that follows back to back simply keeps start high.
   task automatic issue(input logic [31:0] tag, input logic [7:0] cls,
                        input logic [63:0] len, input int idle_pct);
      req_type r;
      r.tag_number     = tag;
      r.class_bits     = cls;
      r.content_length = len;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [31:0] tag;
      logic [63:0] len;
      logic [7:0]  cls;
      logic [2:0]  cls_hi;
      int          idle_pct;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: short/long form boundaries on both the tag and the length,
      // every class value, and the invalid-class error path.
      issue(32'd0,          8'h00, 64'd0,                   0);
      issue(32'd30,         8'hE0, 64'd127,                 0);  // last short forms
      issue(32'd31,         8'h20, 64'd128,                 0);  // first long forms
      issue(32'd127,        8'h40, 64'd255,                 0);  // one tag group
      issue(32'd128,        8'h80, 64'd256,                 0);  // two groups, two len bytes
      issue(32'd16383,      8'hC0, 64'd65535,               0);
      issue(32'd16384,      8'hA0, 64'd65536,               0);
      issue(32'h0FFF_FFFF,  8'h60, 64'h00FF_FFFF_FFFF_FFFF, 0);
      issue(32'h1000_0000,  8'h00, 64'h0100_0000_0000_0000, 0);
      issue(32'hFFFF_FFFF,  8'hE0, 64'hFFFF_FFFF_FFFF_FFFF, 0);  // longest header
      issue(32'hFFFF_FFFF,  8'h00, 64'h8000_0000_0000_0000, 0);
      issue(32'd29,         8'h20, 64'd1,                   0);
      issue(32'd5,          8'h00, 64'hFFFF_FFFF,           0);
      // bad class: any low bit set, tag and length must be ignored
      issue(32'd3,          8'h01, 64'd0,                   0);
      issue(32'd200,        8'h10, 64'd1000,                0);
      issue(32'hFFFF_FFFF,  8'h1F, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      issue(32'd0,          8'hFF, 64'd0,                   0);
      issue(32'h0001_0000,  8'h21, 64'd300,                 0);

      // Random: three pacing phases, sender busy-ish, mostly idle, then flat out.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 36 : (phase == 1) ? 73 : 0;
         for (int n = 0; n < 97; n++) begin
            // random bit widths so short and long forms both get hit often
            tag = $urandom >> (32 - $urandom_range(0, 32));
            len = {$urandom, $urandom} >> (64 - $urandom_range(0, 64));
            if ($urandom_range(0, 99) < 85) begin
               cls_hi = 3'($urandom_range(0, 7));
               cls    = {cls_hi, 5'b0};
            end else begin
               cls = 8'($urandom_range(0, 255));
            end
            issue(tag, cls, len, idle_pct);
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // Drain, then give stray octets time to show up.
      while (octets.outstanding() != 0) @(posedge clock);
      repeat (32) @(posedge clock);

      if (octets.mismatches == 0 && octets.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (about 310 requests at up to
   // 15 octets each plus idle gaps).
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
